>>> rtl/csdf_pkg.sv
package csdf_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned ADDR_BITS  = 5;
  localparam int unsigned DATA_BITS  = 32;

  localparam int unsigned STEPS      = 30;
  localparam int unsigned FRAC_BITS  = 30;
  localparam int unsigned XW         = COORD_BITS + FRAC_BITS + 3;
  localparam int unsigned ZW         = 34;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
  localparam int unsigned RR_BITS    = 2 * (COORD_BITS - 1);
  localparam int unsigned NUM_STAGES = STEPS + 4;

  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  localparam logic [COORD_BITS-1:0] CENTER_X_RST = COORD_BITS'(100);
  localparam logic [COORD_BITS-1:0] CENTER_Y_RST = COORD_BITS'(100);
  localparam logic [COORD_BITS-2:0] RADIUS_RST   = (COORD_BITS-1)'(72);
  localparam logic [ANGLE_BITS-1:0] START_RST    = '0;
  localparam logic [ANGLE_BITS-1:0] END_RST      = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [1:0]            PATTERN_RST  = 2'd0;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_END_ANGLE   = 3'd4,
    REG_PATTERN_SEL = 3'd5
  } reg_idx_e;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_TURNS [0:STEPS-1] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // row index {pattern, x mod 4}, bit index y mod 4 (leftmost is y = 0)
  localparam logic [0:3] DITHER_ROWS [0:15] = '{
    4'b0000, 4'b1010, 4'b0000, 4'b1010,
    4'b0101, 4'b1010, 4'b0101, 4'b1010,
    4'b0101, 4'b1111, 4'b0101, 4'b1111,
    4'b0111, 4'b1111, 4'b1101, 4'b1111
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic color;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-2:0] radius;
    logic [ANGLE_BITS-1:0] start_angle;
    logic [ANGLE_BITS-1:0] end_angle;
    logic [1:0]            pattern_select;
  } cfg_t;

  typedef struct packed {
    logic       in_circle;
    logic       axis;
    logic       diag;
    logic [1:0] quarter;
    logic       dx_neg;
    logic       dy_neg;
    logic [1:0] px_lo;
    logic [1:0] py_lo;
  } side_t;

endpackage

>>> rtl/circle_sector_dither_fill_unit.sv
// throughput: one beat per cycle while out_stall_i is low, set by a 34-stage
//   pipeline (2 circle-test, 30 rotator and 2 fold and classify stages)
// a stalled output only holds stages that are full; bubbles upstream still fill
// reset clears all stage valids and loads the register defaults
module circle_sector_dither_fill_unit import csdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  // register file
  cfg_t     cfg_q;
  reg_idx_e reg_idx;

  assign reg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x       <= CENTER_X_RST;
      cfg_q.center_y       <= CENTER_Y_RST;
      cfg_q.radius         <= RADIUS_RST;
      cfg_q.start_angle    <= START_RST;
      cfg_q.end_angle      <= END_RST;
      cfg_q.pattern_select <= PATTERN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CENTER_X:    cfg_q.center_x       <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y:    cfg_q.center_y       <= pwdata[COORD_BITS-1:0];
        REG_RADIUS:      cfg_q.radius         <= pwdata[COORD_BITS-2:0];
        REG_START_ANGLE: cfg_q.start_angle    <= pwdata[ANGLE_BITS-1:0];
        REG_END_ANGLE:   cfg_q.end_angle      <= pwdata[ANGLE_BITS-1:0];
        REG_PATTERN_SEL: cfg_q.pattern_select <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X:    prdata = DATA_BITS'(cfg_q.center_x);
      REG_CENTER_Y:    prdata = DATA_BITS'(cfg_q.center_y);
      REG_RADIUS:      prdata = DATA_BITS'(cfg_q.radius);
      REG_START_ANGLE: prdata = DATA_BITS'(cfg_q.start_angle);
      REG_END_ANGLE:   prdata = DATA_BITS'(cfg_q.end_angle);
      REG_PATTERN_SEL: prdata = DATA_BITS'(cfg_q.pattern_select);
      default:         prdata = '0;
    endcase
  end

  // stage advance: a stage loads unless stalled with it and all later stages full
  logic [NUM_STAGES-1:0] stage_v;
  logic [NUM_STAGES-1:0] adv;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
    assign adv[k] = !out_stall_i || !(&stage_v[NUM_STAGES-1:k]);
  end

  assign in_stall_o = !adv[0];

  logic [1:0]           prep_v;
  logic signed [XW-1:0] prep_x, prep_y;
  side_t                prep_side;

  csdf_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .adv_i   (adv[1:0]),
    .valid_o (prep_v),
    .x_o     (prep_x),
    .y_o     (prep_y),
    .side_o  (prep_side)
  );

  logic [STEPS-1:0]     cor_v;
  logic signed [ZW-1:0] cor_z;
  side_t                cor_side;

  csdf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_v[1]),
    .x_i     (prep_x),
    .y_i     (prep_y),
    .side_i  (prep_side),
    .adv_i   (adv[STEPS+1:2]),
    .valid_o (cor_v),
    .z_o     (cor_z),
    .side_o  (cor_side)
  );

  logic [1:0] cls_v;

  csdf_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cor_v[STEPS-1]),
    .z_i     (cor_z),
    .side_i  (cor_side),
    .cfg_i   (cfg_q),
    .adv_i   (adv[NUM_STAGES-1:STEPS+2]),
    .valid_o (cls_v),
    .data_o  (out_data_o)
  );

  assign stage_v     = {cls_v, cor_v, prep_v};
  assign out_valid_o = cls_v[1];

endmodule

>>> rtl/csdf_prep.sv
module csdf_prep import csdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  in_item_t             data_i,
  input  cfg_t                 cfg_i,
  input  logic [1:0]           adv_i,
  output logic [1:0]           valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output side_t                side_o
);

  // stage a: offsets, magnitudes, squares
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      ax, ay;
  logic [SQ_BITS-1:0]         sqx, sqy;
  logic [RR_BITS-1:0]         rr;
  side_t                      side_a;

  assign dx  = $signed({1'b0, data_i.pixel_x}) - $signed({1'b0, cfg_i.center_x});
  assign dy  = $signed({1'b0, data_i.pixel_y}) - $signed({1'b0, cfg_i.center_y});
  assign ax  = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ay  = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign sqx = SQ_BITS'(ax) * SQ_BITS'(ax);
  assign sqy = SQ_BITS'(ay) * SQ_BITS'(ay);
  assign rr  = RR_BITS'(cfg_i.radius) * RR_BITS'(cfg_i.radius);

  always_comb begin
    side_a           = '0;
    side_a.dx_neg    = dx[COORD_BITS];
    side_a.dy_neg    = dy[COORD_BITS];
    side_a.px_lo     = data_i.pixel_x[1:0];
    side_a.py_lo     = data_i.pixel_y[1:0];
    side_a.diag      = (ax == ay);
    if (dy == '0) begin
      side_a.axis    = 1'b1;
      side_a.quarter = dx[COORD_BITS] ? 2'd2 : 2'd0;
    end else if (dx == '0) begin
      side_a.axis    = 1'b1;
      side_a.quarter = dy[COORD_BITS] ? 2'd3 : 2'd1;
    end
  end

  logic                  a_v_q;
  logic [COORD_BITS-1:0] a_ax_q, a_ay_q;
  logic [SQ_BITS-1:0]    a_sqx_q, a_sqy_q;
  logic [RR_BITS-1:0]    a_rr_q;
  side_t                 a_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv_i[0]) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      a_ax_q   <= ax;
      a_ay_q   <= ay;
      a_sqx_q  <= sqx;
      a_sqy_q  <= sqy;
      a_rr_q   <= rr;
      a_side_q <= side_a;
    end
  end

  // stage b: circle test and rotator seed
  logic [SQ_BITS:0] dist2;
  side_t            side_b;

  assign dist2 = (SQ_BITS+1)'(a_sqx_q) + (SQ_BITS+1)'(a_sqy_q);

  always_comb begin
    side_b           = a_side_q;
    side_b.in_circle = (dist2 <= (SQ_BITS+1)'(a_rr_q));
  end

  logic                 b_v_q;
  logic signed [XW-1:0] b_x_q, b_y_q;
  side_t                b_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv_i[1]) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      b_x_q    <= $signed(XW'({a_ax_q, {FRAC_BITS{1'b0}}}));
      b_y_q    <= $signed(XW'({a_ay_q, {FRAC_BITS{1'b0}}}));
      b_side_q <= side_b;
    end
  end

  assign valid_o = {b_v_q, a_v_q};
  assign x_o     = b_x_q;
  assign y_o     = b_y_q;
  assign side_o  = b_side_q;

endmodule

>>> rtl/csdf_cordic.sv
module csdf_cordic import csdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  side_t                side_i,
  input  logic [STEPS-1:0]     adv_i,
  output logic [STEPS-1:0]     valid_o,
  output logic signed [ZW-1:0] z_o,
  output side_t                side_o
);

  logic [STEPS:0]       v_s;
  logic signed [XW-1:0] x_s [0:STEPS-2];
  logic signed [XW-1:0] y_s [0:STEPS-1];
  logic signed [ZW-1:0] z_s [0:STEPS];
  side_t                side_s [0:STEPS];

  assign v_s[0]    = valid_i;
  assign x_s[0]    = x_i;
  assign y_s[0]    = y_i;
  assign z_s[0]    = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic signed [ZW-1:0] AngK = $signed({2'b00, ATAN_TURNS[k]});
    logic rot_pos;

    assign rot_pos = !y_s[k][XW-1] && (y_s[k] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (adv_i[k]) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[k]) begin
        z_s[k+1]    <= rot_pos ? z_s[k] + AngK : z_s[k] - AngK;
        side_s[k+1] <= side_s[k];
      end
    end

    if (k <= STEPS - 2) begin : g_y
      always_ff @(posedge clk_i) begin
        if (adv_i[k]) begin
          y_s[k+1] <= rot_pos ? y_s[k] - (x_s[k] >>> k) : y_s[k] + (x_s[k] >>> k);
        end
      end
    end

    if (k <= STEPS - 3) begin : g_x
      always_ff @(posedge clk_i) begin
        if (adv_i[k]) begin
          x_s[k+1] <= rot_pos ? x_s[k] + (y_s[k] >>> k) : x_s[k] - (y_s[k] >>> k);
        end
      end
    end
  end

  assign valid_o = v_s[STEPS:1];
  assign z_o     = z_s[STEPS];
  assign side_o  = side_s[STEPS];

endmodule

>>> rtl/csdf_classify.sv
module csdf_classify import csdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [ZW-1:0] z_i,
  input  side_t                side_i,
  input  cfg_t                 cfg_i,
  input  logic [1:0]           adv_i,
  output logic [1:0]           valid_o,
  output out_item_t            data_o
);

  // stage f: clamp and quadrant fold
  logic [31:0] phi, bear;

  always_comb begin
    if (side_i.diag) begin
      phi = EIGHTH_TURN;
    end else if (z_i[ZW-1]) begin
      phi = '0;
    end else if (z_i > $signed(ZW'(QUARTER_TURN))) begin
      phi = QUARTER_TURN;
    end else begin
      phi = z_i[31:0];
    end
  end

  always_comb begin
    if (side_i.axis) begin
      bear = {side_i.quarter, 30'b0};
    end else begin
      unique case ({side_i.dx_neg, side_i.dy_neg})
        2'b00:   bear = phi;
        2'b10:   bear = HALF_TURN - phi;
        2'b11:   bear = HALF_TURN + phi;
        default: bear = 32'd0 - phi;
      endcase
    end
  end

  logic                  f_v_q;
  logic [ANGLE_BITS-1:0] f_ang_q;
  side_t                 f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (adv_i[0]) begin
      f_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      f_ang_q  <= bear[31 -: ANGLE_BITS];
      f_side_q <= side_i;
    end
  end

  // stage o: range test and dither color
  logic      in_rng;
  out_item_t res_d;

  always_comb begin
    if (cfg_i.start_angle <= cfg_i.end_angle) begin
      in_rng = (f_ang_q >= cfg_i.start_angle) && (f_ang_q <= cfg_i.end_angle);
    end else begin
      in_rng = (f_ang_q >= cfg_i.start_angle) || (f_ang_q <= cfg_i.end_angle);
    end
    res_d.inside_res = f_side_q.in_circle && in_rng;
    res_d.color      = res_d.inside_res &&
                       DITHER_ROWS[{cfg_i.pattern_select, f_side_q.px_lo}][f_side_q.py_lo];
  end

  logic      o_v_q;
  out_item_t o_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (adv_i[1]) begin
      o_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      o_res_q <= res_d;
    end
  end

  assign valid_o = {o_v_q, f_v_q};
  assign data_o  = o_res_q;

endmodule
